// File: sv/blt_pkg.sv
// Shared types, constants and sizes for the Bernsen local threshold unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package blt_pkg;

  // Storage sizes.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 7;

  // Field and register widths fixed by the interface.
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int OUT_COL_W  = 10;
  localparam int WSIZE_W    = 3;
  localparam int IWIDTH_W   = 11;
  localparam int CMIN_W     = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Widths that follow from the storage sizes.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EFFW_W = $clog2(MAX_WIDTH + 1);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int SPAN_W = $clog2(MAX_WINDOW);
  localparam int HALF_W = $clog2(MAX_WINDOW / 2 + 1);

  localparam int FLAT_THRESHOLD = 128;
  localparam int PIX_HIGH       = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_CONTRAST_MIN = 2'd2
  } cfg_reg_t;

  // Working form of the configuration registers.
  typedef struct packed {
    logic                pass;
    logic [SPAN_W-1:0]   span;
    logic [HALF_W-1:0]   half;
    logic [EFFW_W-1:0]   width;
    logic [CMIN_W-1:0]   contrast_min;
  } cfg_t;

  // One pixel on its way through the pipeline.
  typedef struct packed {
    logic [PIX_W-1:0]     pixel;
    logic [SLOT_W-1:0]    slot;
    logic [ROW_W-1:0]     orow;
    logic [OUT_COL_W-1:0] ocol;
    logic                 emit;
    logic                 pass;
  } item_t;

  // Window statistics handed to the decision stage.
  typedef struct packed {
    logic [PIX_W-1:0]     lo;
    logic [PIX_W-1:0]     hi;
    logic [PIX_W-1:0]     ctr;
    logic [ROW_W-1:0]     orow;
    logic [OUT_COL_W-1:0] ocol;
    logic                 pass;
  } win_t;

endpackage

`default_nettype wire

// File: sv/blt_if.sv
// Stream interfaces for source pixels and thresholded results.
// Depends on blt_pkg for field widths.
`default_nettype none

interface blt_in_if;
  logic                      valid;
  logic                      ready;
  logic [blt_pkg::PIX_W-1:0] pixel;
  logic                      frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface blt_out_if;
  logic                          valid;
  logic                          ready;
  logic [blt_pkg::ROW_W-1:0]     out_row;
  logic [blt_pkg::OUT_COL_W-1:0] out_col;
  logic [blt_pkg::PIX_W-1:0]     out_value;

  modport source (output valid, out_row, out_col, out_value, input ready);
  modport sink   (input valid, out_row, out_col, out_value, output ready);
endinterface

`default_nettype wire

// File: sv/blt_addr_gen.sv
// Row and column counters and line store slot for the incoming pixel.
// Depends on blt_pkg.
`default_nettype none

module blt_addr_gen (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [blt_pkg::PIX_W-1:0] pixel,
  input  wire logic                      frame_start,
  input  wire blt_pkg::cfg_t             cfg,
  output blt_pkg::item_t                 item,
  output logic [blt_pkg::COL_W-1:0]      col_addr
);

  logic [blt_pkg::ROW_W-1:0]  row_cnt, row_a, row_inc, row_cnt_next;
  logic [blt_pkg::COL_W-1:0]  col_cnt, col_a, col_cnt_next;
  logic [blt_pkg::SLOT_W-1:0] slot_cnt, slot_a, slot_cnt_next;
  logic [blt_pkg::EFFW_W-1:0] col_inc;

  // The slot follows the row modulo the store depth and restarts when the row wraps.
  function automatic logic [blt_pkg::SLOT_W-1:0] slot_step(
    input logic [blt_pkg::ROW_W-1:0]  new_row,
    input logic [blt_pkg::SLOT_W-1:0] s
  );
    logic [blt_pkg::SLOT_W-1:0] r;
    if (new_row == '0 || s == blt_pkg::SLOT_W'(blt_pkg::MAX_WINDOW - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    row_a  = frame_start ? '0 : row_cnt;
    col_a  = frame_start ? '0 : col_cnt;
    slot_a = frame_start ? '0 : slot_cnt;
    // A width that shrank under a running row starts a new row here.
    if (blt_pkg::EFFW_W'(col_a) >= cfg.width) begin
      row_a  = row_a + 1'b1;
      slot_a = slot_step(row_a, slot_a);
      col_a  = '0;
    end
    col_inc = blt_pkg::EFFW_W'(col_a) + 1'b1;
    row_inc = row_a + 1'b1;
    if (col_inc >= cfg.width) begin
      col_cnt_next  = '0;
      row_cnt_next  = row_inc;
      slot_cnt_next = slot_step(row_inc, slot_a);
    end else begin
      col_cnt_next  = blt_pkg::COL_W'(col_inc);
      row_cnt_next  = row_a;
      slot_cnt_next = slot_a;
    end

    item.pixel = pixel;
    item.slot  = slot_a;
    item.pass  = cfg.pass;
    item.emit  = cfg.pass || (row_a >= blt_pkg::ROW_W'(cfg.span) &&
                              col_a >= blt_pkg::COL_W'(cfg.span));
    item.orow  = cfg.pass ? row_a : row_a - blt_pkg::ROW_W'(cfg.half);
    item.ocol  = blt_pkg::OUT_COL_W'(cfg.pass ? col_a
                                              : col_a - blt_pkg::COL_W'(cfg.half));
    col_addr   = col_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      slot_cnt <= '0;
    end else if (accept) begin
      row_cnt  <= row_cnt_next;
      col_cnt  <= col_cnt_next;
      slot_cnt <= slot_cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/blt_line_buf.sv
// Line store banks, one per buffered row, and the first pipeline register.
// Depends on blt_pkg.
`default_nettype none

module blt_line_buf (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire blt_pkg::item_t              item_in,
  input  wire logic [blt_pkg::COL_W-1:0]   col_addr,
  output logic                             valid,
  input  wire logic                        ready,
  output blt_pkg::item_t                   item,
  output logic [blt_pkg::PIX_W-1:0]        bank_data [blt_pkg::MAX_WINDOW]
);

  logic accept;

  assign in_ready = !valid || ready;
  assign accept   = in_valid && in_ready;

  // Every bank is read at the current column; the bank for the current row
  // takes the new pixel, and its stale read is never used.
  for (genvar b = 0; b < blt_pkg::MAX_WINDOW; b++) begin : g_bank
    logic [blt_pkg::PIX_W-1:0] mem [blt_pkg::MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (accept) begin
        if (item_in.slot == blt_pkg::SLOT_W'(b)) begin
          mem[col_addr] <= item_in.pixel;
        end
        bank_data[b] <= mem[col_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

// File: sv/blt_window.sv
// Column minimum and maximum registers sliding along the row, then the
// window minimum and maximum. Depends on blt_pkg.
`default_nettype none

module blt_window (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire blt_pkg::cfg_t               cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire blt_pkg::item_t              item_in,
  input  wire logic [blt_pkg::PIX_W-1:0]   bank_data [blt_pkg::MAX_WINDOW],
  output logic                             valid,
  input  wire logic                        ready,
  output blt_pkg::win_t                    win
);

  localparam int NW = blt_pkg::MAX_WINDOW;

  logic                        col_valid, col_ready, win_ready;
  blt_pkg::item_t              col_item;
  logic [blt_pkg::PIX_W-1:0]   colv [NW];
  logic [blt_pkg::SLOT_W-1:0]  bank_idx [NW];
  logic [blt_pkg::PIX_W-1:0]   new_min, new_max;
  logic [blt_pkg::PIX_W-1:0]   cmin [NW];
  logic [blt_pkg::PIX_W-1:0]   cmax [NW];
  logic [blt_pkg::PIX_W-1:0]   cctr [NW];
  blt_pkg::win_t               win_next;

  assign win_ready = !valid || ready;
  assign col_ready = !col_valid || win_ready;
  assign in_ready  = col_ready;

  // Gather the new column: distance zero is the incoming pixel, distance d
  // lies in the bank of the row d lines above.
  always_comb begin
    new_min = blt_pkg::PIX_W'(blt_pkg::PIX_HIGH);
    new_max = '0;
    for (int d = 0; d < NW; d++) begin
      if (item_in.slot < blt_pkg::SLOT_W'(d)) begin
        bank_idx[d] = item_in.slot + blt_pkg::SLOT_W'(NW - d);
      end else begin
        bank_idx[d] = item_in.slot - blt_pkg::SLOT_W'(d);
      end
      colv[d] = (d == 0) ? item_in.pixel : bank_data[bank_idx[d]];
      if (d <= int'(cfg.span)) begin
        if (colv[d] < new_min) new_min = colv[d];
        if (colv[d] > new_max) new_max = colv[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= 1'b0;
    end else if (col_ready) begin
      col_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && col_ready) begin
      col_item <= item_in;
      cmin[0]  <= new_min;
      cmax[0]  <= new_max;
      cctr[0]  <= colv[blt_pkg::SLOT_W'(cfg.half)];
      for (int j = 1; j < NW; j++) begin
        cmin[j] <= cmin[j-1];
        cmax[j] <= cmax[j-1];
        cctr[j] <= cctr[j-1];
      end
    end
  end

  // Entry j holds the column j places left of the newest one.
  always_comb begin
    win_next.lo   = blt_pkg::PIX_W'(blt_pkg::PIX_HIGH);
    win_next.hi   = '0;
    for (int j = 0; j < NW; j++) begin
      if (j <= int'(cfg.span)) begin
        if (cmin[j] < win_next.lo) win_next.lo = cmin[j];
        if (cmax[j] > win_next.hi) win_next.hi = cmax[j];
      end
    end
    win_next.ctr  = col_item.pass ? col_item.pixel : cctr[blt_pkg::SLOT_W'(cfg.half)];
    win_next.orow = col_item.orow;
    win_next.ocol = col_item.ocol;
    win_next.pass = col_item.pass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (win_ready) begin
      valid <= col_valid && col_item.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (col_valid && win_ready) begin
      win <= win_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/blt_decide.sv
// Threshold choice and binarisation, into the output register.
// Depends on blt_pkg and blt_if.
`default_nettype none

module blt_decide (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire blt_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire blt_pkg::win_t win,
  blt_out_if.source          results
);

  logic [blt_pkg::PIX_W-1:0] diff, thr, bin_value;
  logic [blt_pkg::PIX_W:0]   mid_sum;

  assign in_ready = !results.valid || results.ready;

  always_comb begin
    diff    = win.hi - win.lo;
    mid_sum = {1'b0, win.lo} + {1'b0, win.hi} + 1'b1;
    // Flat windows fall back to the fixed mid-grey threshold.
    if (diff < cfg.contrast_min) begin
      thr = blt_pkg::PIX_W'(blt_pkg::FLAT_THRESHOLD);
    end else begin
      thr = mid_sum[blt_pkg::PIX_W:1];
    end
    bin_value = (win.ctr >= thr) ? blt_pkg::PIX_W'(blt_pkg::PIX_HIGH) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (in_ready) begin
      results.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      results.out_row   <= win.orow;
      results.out_col   <= win.ocol;
      results.out_value <= win.pass ? win.ctr : bin_value;
    end
  end

endmodule

`default_nettype wire

// File: sv/bernsen_local_threshold_unit.sv
// Bernsen local threshold unit: streaming min/max window binariser.
// The beat completing a window passes line store, column, window and output registers.
// Throughput: one pixel beat per cycle while results are not stalled, set by the single
// read port of each line store bank and the one-column-per-beat window slide.
// Reset clears counters, pipeline valids and loads the register defaults;
// the line store is not cleared.
`default_nettype none

module bernsen_local_threshold_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  blt_in_if.sink                              pixels,
  blt_out_if.source                           results,
  input  wire logic                           cfg_en,
  input  wire logic [blt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blt_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [blt_pkg::WSIZE_W-1:0]  window_size;
  logic [blt_pkg::IWIDTH_W-1:0] image_width;
  logic [blt_pkg::CMIN_W-1:0]   contrast_min;
  logic [blt_pkg::WSIZE_W-1:0]  k_eff;
  blt_pkg::cfg_t                cfg;

  blt_pkg::item_t               gen_item, lb_item;
  logic [blt_pkg::COL_W-1:0]    col_addr;
  logic [blt_pkg::PIX_W-1:0]    bank_data [blt_pkg::MAX_WINDOW];
  logic                         accept, lb_valid, lb_ready;
  logic                         win_valid, win_ready;
  blt_pkg::win_t                win;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= blt_pkg::WSIZE_W'(3);
      image_width  <= blt_pkg::IWIDTH_W'(1024);
      contrast_min <= blt_pkg::CMIN_W'(15);
    end else if (cfg_en) begin
      case (cfg_index)
        blt_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[blt_pkg::WSIZE_W-1:0];
        blt_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[blt_pkg::IWIDTH_W-1:0];
        blt_pkg::REG_CONTRAST_MIN: contrast_min <= cfg_data[blt_pkg::CMIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    k_eff = window_size;
    if (int'(window_size) > blt_pkg::MAX_WINDOW) begin
      k_eff = blt_pkg::WSIZE_W'((blt_pkg::MAX_WINDOW - 1) | 1);
    end
    cfg.pass = (k_eff <= blt_pkg::WSIZE_W'(1)) || !k_eff[0];
    cfg.span = blt_pkg::SPAN_W'(k_eff - 1'b1);
    cfg.half = blt_pkg::HALF_W'(cfg.span >> 1);
    if (image_width == '0) begin
      cfg.width = blt_pkg::EFFW_W'(1);
    end else if (int'(image_width) > blt_pkg::MAX_WIDTH) begin
      cfg.width = blt_pkg::EFFW_W'(blt_pkg::MAX_WIDTH);
    end else begin
      cfg.width = blt_pkg::EFFW_W'(image_width);
    end
    cfg.contrast_min = contrast_min;
  end

  assign accept = pixels.valid && pixels.ready;

  blt_addr_gen u_addr_gen (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel       (pixels.pixel),
    .frame_start (pixels.frame_start),
    .cfg         (cfg),
    .item        (gen_item),
    .col_addr    (col_addr)
  );

  blt_line_buf u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .item_in   (gen_item),
    .col_addr  (col_addr),
    .valid     (lb_valid),
    .ready     (lb_ready),
    .item      (lb_item),
    .bank_data (bank_data)
  );

  blt_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (lb_valid),
    .in_ready  (lb_ready),
    .item_in   (lb_item),
    .bank_data (bank_data),
    .valid     (win_valid),
    .ready     (win_ready),
    .win       (win)
  );

  blt_decide u_decide (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (win_valid),
    .in_ready (win_ready),
    .win      (win),
    .results  (results)
  );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for bernsen_local_threshold_unit: directed frames, random frames, then a largest-window frame.
// It predicts each result pixel and compares it with the result stream.
// Depends on blt_pkg, blt_if and the unit under test.

module testbench;

  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_REPORTS  = 40;
  localparam int RANDOM_BEATS = 650;

  typedef struct packed {
    logic [blt_pkg::PIX_W-1:0] pixel;
    logic                      frame_start;
  } gray_beat_t;

  typedef struct packed {
    logic [blt_pkg::ROW_W-1:0]     row;
    logic [blt_pkg::OUT_COL_W-1:0] col;
    logic [blt_pkg::PIX_W-1:0]     value;
  } bin_pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic                           cfg_en;
  logic [blt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [blt_pkg::CFG_DATA_W-1:0] cfg_data;

  blt_in_if  gray_in ();
  blt_out_if bin_out ();

  bernsen_local_threshold_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .pixels    (gray_in),
    .results   (bin_out),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus and expectations.
  gray_beat_t pending_beats [$];
  bin_pixel_t expected_pixels [$];
  gray_beat_t next_beat;
  int beats_queued = 0;
  int beats_taken  = 0;
  int fail_count   = 0;
  int idle_odds    = 0;
  int hold_requests = 0;
  int hold_served   = 0;

  // Predictor state: its own copy of the registers, counters and line store.
  logic [blt_pkg::WSIZE_W-1:0]  cur_wsize;
  logic [blt_pkg::IWIDTH_W-1:0] cur_width;
  logic [blt_pkg::CMIN_W-1:0]   cur_cmin;
  int row_pos;
  int col_pos;
  logic [blt_pkg::PIX_W-1:0] gray_rows [blt_pkg::MAX_WINDOW][blt_pkg::MAX_WIDTH];

  task automatic threshold_predict(input logic [blt_pkg::PIX_W-1:0] pix, input logic fs);
    int w, k, span, half, r0, c0, lo, hi, thr, i, j;
    logic [blt_pkg::PIX_W-1:0] v, centre;
    bin_pixel_t e;
    w = int'(cur_width);
    if (w == 0) w = 1;
    if (w > blt_pkg::MAX_WIDTH) w = blt_pkg::MAX_WIDTH;
    k = int'(cur_wsize);
    if (k > blt_pkg::MAX_WINDOW) k = (blt_pkg::MAX_WINDOW - 1) | 1;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    // A width shrunk under a running row closes that row here.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 16'hFFFF;
    end
    gray_rows[row_pos % blt_pkg::MAX_WINDOW][col_pos] = pix;
    if (k <= 1 || (k % 2) == 0) begin
      e.row   = row_pos[blt_pkg::ROW_W-1:0];
      e.col   = col_pos[blt_pkg::OUT_COL_W-1:0];
      e.value = pix;
      expected_pixels.push_back(e);
    end else begin
      span = k - 1;
      half = span / 2;
      if (row_pos >= span && col_pos >= span) begin
        r0 = row_pos - span;
        c0 = col_pos - span;
        lo = 255;
        hi = 0;
        for (i = 0; i < k; i++) begin
          for (j = 0; j < k; j++) begin
            v = gray_rows[(r0 + i) % blt_pkg::MAX_WINDOW][c0 + j];
            if (v < lo) lo = v;
            if (v > hi) hi = v;
          end
        end
        centre = gray_rows[(r0 + half) % blt_pkg::MAX_WINDOW][c0 + half];
        if (hi - lo < int'(cur_cmin)) thr = blt_pkg::FLAT_THRESHOLD;
        else thr = (lo + hi + 1) >> 1;
        e.row   = blt_pkg::ROW_W'(row_pos - half);
        e.col   = blt_pkg::OUT_COL_W'(col_pos - half);
        e.value = (int'(centre) >= thr) ? blt_pkg::PIX_W'(blt_pkg::PIX_HIGH) : '0;
        expected_pixels.push_back(e);
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 16'hFFFF;
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Driver: offers queued pixel beats, with random gaps between them.
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      gray_in.valid       <= 1'b0;
      gray_in.pixel       <= '0;
      gray_in.frame_start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (gray_in.valid && gray_in.ready) begin
        threshold_predict(gray_in.pixel, gray_in.frame_start);
        beats_taken++;
      end
      if (!gray_in.valid || gray_in.ready) begin
        if (gap_left != 0) begin
          gray_in.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_beats.size() == 0) begin
          gray_in.valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, 15) < idle_odds) begin
          gray_in.valid <= 1'b0;
          gap_left <= $urandom_range(0, 7);
        end else begin
          next_beat = pending_beats.pop_front();
          gray_in.valid       <= 1'b1;
          gray_in.pixel       <= next_beat.pixel;
          gray_in.frame_start <= next_beat.frame_start;
        end
      end
    end
  end

  // Monitor: checks each result beat and drives ready with random stalls.
  bin_pixel_t got_pixel;
  int stall_left;
  int hold_left;
  always @(posedge clk) begin
    if (rst) begin
      bin_out.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (bin_out.valid && bin_out.ready) begin
        if (expected_pixels.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual row %0d col %0d value %0d",
                     $time, bin_out.out_row, bin_out.out_col, bin_out.out_value);
          fail_count++;
        end else begin
          got_pixel = expected_pixels.pop_front();
          check_field("out_row", got_pixel.row, bin_out.out_row);
          check_field("out_col", got_pixel.col, bin_out.out_col);
          check_field("out_value", got_pixel.value, bin_out.out_value);
        end
      end
      if (hold_left != 0) begin
        bin_out.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
        bin_out.ready <= 1'b0;
        hold_left <= LONG_HOLD - 1;
        hold_served <= hold_requests;
      end else if (stall_left != 0) begin
        bin_out.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idle_odds != 0 && $urandom_range(0, 15) < idle_odds) begin
        bin_out.ready <= 1'b0;
        stall_left <= $urandom_range(0, 7);
      end else begin
        bin_out.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((gray_in.valid && gray_in.ready) || (bin_out.valid && bin_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[bernsen_local_threshold_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input blt_pkg::cfg_reg_t idx,
                           input logic [blt_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      blt_pkg::REG_WINDOW_SIZE:  cur_wsize = data[blt_pkg::WSIZE_W-1:0];
      blt_pkg::REG_IMAGE_WIDTH:  cur_width = data[blt_pkg::IWIDTH_W-1:0];
      blt_pkg::REG_CONTRAST_MIN: cur_cmin  = data[blt_pkg::CMIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  task automatic set_regs(input logic [blt_pkg::CFG_DATA_W-1:0] wsize,
                          input logic [blt_pkg::CFG_DATA_W-1:0] width,
                          input logic [blt_pkg::CFG_DATA_W-1:0] cmin);
    write_reg(blt_pkg::REG_WINDOW_SIZE, wsize);
    write_reg(blt_pkg::REG_IMAGE_WIDTH, width);
    write_reg(blt_pkg::REG_CONTRAST_MIN, cmin);
  endtask

  task automatic push_beat(input logic [blt_pkg::PIX_W-1:0] pix, input logic fs);
    gray_beat_t b;
    b.pixel = pix;
    b.frame_start = fs;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  function automatic logic [blt_pkg::PIX_W-1:0] pick_pixel(input int mode, input int base);
    case (mode)
      1:       return blt_pkg::PIX_W'(base + $urandom_range(0, 12));
      2:       return $urandom_range(0, 1) ? blt_pkg::PIX_W'(blt_pkg::PIX_HIGH) : '0;
      3:       return blt_pkg::PIX_W'($urandom_range(120, 136));
      default: return blt_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame of rows x w pixels plus a tail; stray > 0 puts a frame start mid-frame.
  task automatic push_frame(input int w, input int rows, input int tail, input int mode,
                            input bit fresh, input int stray);
    int i, len, base;
    len = w * rows + tail;
    base = $urandom_range(0, 243);
    for (i = 0; i < len; i++)
      push_beat(pick_pixel(mode, base), (fresh && i == 0) || (stray > 0 && i == stray));
  endtask

  // Waits until every beat has gone in and every result has come out.
  task automatic wait_quiet();
    while (beats_taken != beats_queued || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [blt_pkg::PIX_W-1:0] grid [9];
    int i, k, w, rows, tail, ew, mode, stray, frames, start_beats, pick;
    logic [blt_pkg::CFG_DATA_W-1:0] cmin, wsize_word, cmin_word;

    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = blt_pkg::REG_WINDOW_SIZE;
    cfg_data = '0;
    cur_wsize = 3'd3;
    cur_width = 11'd1024;
    cur_cmin = 8'd15;
    row_pos = 0;
    col_pos = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Passthrough with a one-pixel row: width zero acts as one.
    set_regs(11'd1, 11'd0, 11'd0);
    push_beat(8'd0, 1'b1);
    push_beat(8'd255, 1'b0);
    push_beat(8'hAA, 1'b0);
    push_beat(8'h55, 1'b0);
    wait_quiet();

    // Window size zero and a width above the line store, with a restart mid-frame.
    set_regs(11'd0, 11'd2047, 11'd255);
    push_beat(8'd1, 1'b1);
    push_beat(8'd254, 1'b0);
    push_beat(8'd127, 1'b1);
    push_beat(8'd128, 1'b0);
    wait_quiet();

    // Full contrast against the largest minimum: the midpoint 128 equals the centre.
    set_regs(11'd3, 11'd3, 11'd255);
    grid = '{8'd0, 8'd10, 8'd20, 8'd30, 8'd128, 8'd40, 8'd50, 8'd60, 8'd255};
    for (i = 0; i < 9; i++) push_beat(grid[i], i == 0);
    wait_quiet();

    // Midpoint variant, centre one below the rounded midpoint.
    set_regs(11'd3, 11'd3, 11'd0);
    grid[4] = 8'd127;
    for (i = 0; i < 9; i++) push_beat(grid[i], i == 0);
    wait_quiet();

    // A width above the line store wraps the row at full width; passthrough keeps
    // results flowing while the receiver holds off long enough to back the block up.
    idle_odds = 2;
    set_regs(11'd1, 11'd2047, 11'd40);
    hold_requests++;
    push_frame(blt_pkg::MAX_WIDTH, 1, 8, 0, 1'b1, 0);
    wait_quiet();

    // Width shrunk while a row is half done: the next beat opens a new row.
    set_regs(11'd3, 11'd10, 11'd20);
    push_frame(10, 5, 4, 0, 1'b1, 0);
    wait_quiet();
    write_reg(blt_pkg::REG_IMAGE_WIDTH, 11'd3);
    push_frame(3, 4, 0, 0, 1'b0, 0);
    wait_quiet();

    // Random frames, mostly well formed.
    start_beats = beats_queued;
    while (beats_queued - start_beats < RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) k = 3 + 2 * $urandom_range(0, 2);
      else k = (pick == 7) ? $urandom_range(0, 1) : 2 * $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, k);
      else w = $urandom_range((k < 1) ? 1 : k, k + 12);
      case ($urandom_range(0, 7))
        0:       cmin = 11'd0;
        1:       cmin = 11'd255;
        2:       cmin = blt_pkg::CFG_DATA_W'($urandom_range(1, 20));
        default: cmin = blt_pkg::CFG_DATA_W'($urandom_range(0, 255));
      endcase
      // Upper data bits above the window size and contrast minimum fields are noise.
      wsize_word = (blt_pkg::CFG_DATA_W'($urandom_range(0, 255)) << blt_pkg::WSIZE_W)
                   | blt_pkg::CFG_DATA_W'(k);
      cmin_word  = (blt_pkg::CFG_DATA_W'($urandom_range(0, 7)) << blt_pkg::CMIN_W) | cmin;
      set_regs(wsize_word, blt_pkg::CFG_DATA_W'(w), cmin_word);
      idle_odds = $urandom_range(0, 4);
      ew = (w == 0) ? 1 : w;
      frames = $urandom_range(1, 2);
      for (i = 0; i < frames; i++) begin
        rows = $urandom_range((k < 1) ? 1 : k, k + 5);
        mode = $urandom_range(0, 3);
        tail = 0;
        stray = 0;
        // Now and then a cut-off frame or a stray frame start.
        if ($urandom_range(0, 5) == 0) begin
          rows = rows - 1;
          tail = $urandom_range(0, ew - 1);
        end
        if ($urandom_range(0, 7) == 0) stray = $urandom_range(1, ew * rows);
        push_frame(ew, rows, tail, mode, 1'b1, stray);
      end
      wait_quiet();
    end

    // Largest window, back to back with no idling on either side.
    idle_odds = 0;
    set_regs(11'd7, 11'd9, blt_pkg::CFG_DATA_W'($urandom_range(0, 255)));
    push_frame(9, 10, 0, 0, 1'b1, 0);
    wait_quiet();

    if (fail_count == 0) begin
      $display("[bernsen_local_threshold_unit] OK");
    end else begin
      $display("[bernsen_local_threshold_unit] ERROR");
    end
    $finish;
  end

endmodule
